### hw/rtl/tws_pkg.sv
// Shared constants, types and codes for the trie word store.
// No dependencies; imported by tws_ctrl, the top level and the checker.
package tws_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ALPHABET  = 26;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int FREE_W    = $clog2(MAX_NODES + 1);
    localparam int OP_W      = 2;
    localparam int LETTER_W  = 5;

    // One row per node: ALPHABET child indexes, then one end bit per child.
    localparam int END_BASE  = ALPHABET * NODE_W;
    localparam int ROW_W     = ALPHABET * (NODE_W + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef struct packed {
        logic  we;
        node_t waddr;
        row_t  wdata;
        logic  re;
        node_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic status;
    } result_t;

endpackage

### hw/rtl/tws_row_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module tws_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tws_ctrl.sv
// Walk sequencer: clearing sweep, per-letter read-modify-write of node rows.
// Depends on tws_pkg.
module tws_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [tws_pkg::OP_W-1:0]     opcode,
    input  logic [tws_pkg::LETTER_W-1:0] letter,
    input  logic                     last,
    input  logic                     out_free,
    output tws_pkg::result_t         res,
    output tws_pkg::ram_req_t        ram_req,
    input  tws_pkg::row_t            ram_rdata
);
    import tws_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]          state_reg, state_next;
    node_t               clr_addr_reg, clr_addr_next;
    node_t               cur_reg, cur_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic                miss_reg, miss_next;
    logic                full_reg, full_next;
    logic [OP_W-1:0]     op_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                last_reg;

    logic  accept;
    logic  letter_ok;
    logic  is_ins;
    logic  stopped;
    node_t child;
    logic  end_bit;
    logic  step_miss, step_full, create, advance, mark;
    logic  miss_n, full_n;
    logic  proceed;
    node_t new_child;
    row_t  row_new;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            letter_reg <= letter;
            last_reg   <= last;
        end
    end

    // lane select out of the row
    always_comb
    begin
        child   = '0;
        end_bit = 1'b0;
        for (int l = 0; l < ALPHABET; l++)
        begin
            if (32'(letter_reg) == l)
            begin
                child   = ram_rdata[l*NODE_W +: NODE_W];
                end_bit = ram_rdata[END_BASE + l];
            end
        end
    end

    assign letter_ok = (32'(letter_reg) < ALPHABET);
    assign is_ins    = (op_reg == OP_INSERT);
    assign stopped   = miss_reg || full_reg;

    assign step_miss = !stopped && (!letter_ok || ((child == '0) && !is_ins));
    assign step_full = !stopped && letter_ok && (child == '0) && is_ins
                       && (free_reg == FREE_W'(MAX_NODES));
    assign create    = !stopped && letter_ok && (child == '0) && is_ins
                       && (free_reg != FREE_W'(MAX_NODES));
    assign advance   = !stopped && !step_miss && !step_full;
    assign miss_n    = miss_reg || step_miss;
    assign full_n    = full_reg || step_full;
    assign mark      = last_reg && is_ins && !miss_n && !full_n;
    assign new_child = create ? free_reg[NODE_W-1:0] : child;

    always_comb
    begin
        row_new = ram_rdata;
        for (int l = 0; l < ALPHABET; l++)
        begin
            if (32'(letter_reg) == l)
            begin
                row_new[l*NODE_W +: NODE_W] = new_child;
                row_new[END_BASE + l]       = ram_rdata[END_BASE + l] | mark;
            end
        end
    end

    // a last letter waits in EXEC until the output register can take it
    assign proceed = (state_reg == ST_EXEC) && (!last_reg || out_free);

    always_comb
    begin
        res.valid  = proceed && last_reg;
        res.status = is_ins && full_n;
        if (is_ins)
        begin
            res.hit = !miss_n && !full_n;
        end
        else
        begin
            res.hit = !miss_n && !full_n && ((op_reg == OP_EXACT) ? end_bit : 1'b1);
        end
    end

    always_comb
    begin
        ram_req.re    = accept;
        ram_req.raddr = cur_reg;
        if (state_reg == ST_CLEAR)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_addr_reg;
            ram_req.wdata = '0;
        end
        else
        begin
            ram_req.we    = proceed && (create || mark);
            ram_req.waddr = cur_reg;
            ram_req.wdata = row_new;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        miss_next     = miss_reg;
        full_next     = full_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == NODE_W'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (proceed)
                begin
                    state_next = ST_IDLE;
                    if (create)
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        cur_next  = '0;
                        miss_next = 1'b0;
                        full_next = 1'b0;
                    end
                    else
                    begin
                        cur_next  = advance ? new_child : cur_reg;
                        miss_next = miss_n;
                        full_next = full_n;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cur_reg      <= '0;
            free_reg     <= FREE_W'(1);
            miss_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cur_reg      <= cur_next;
            free_reg     <= free_next;
            miss_reg     <= miss_next;
            full_reg     <= full_next;
        end
    end

endmodule

### hw/rtl/trie_word_store_top.sv
// Channel      | signals                      | transaction
// -------------+------------------------------+---------------------------------
// input        | in_valid/in_ready            | opcode, letter, last (one letter)
// output       | out_valid/out_ready          | hit, status (one per last letter)
//
// Each letter is a row read of the current node when the letter is taken, then
// select and write-back; the next letter's read address is the node found by
// this one, or the root after a last letter. After reset the node memory is
// swept to zero, one row a cycle, over all MAX_NODES rows (1024) with in_ready low.
// A result waiting in the output register does not block the next letter; a
// last letter holds in EXEC until the output register is free.
// Top level: trie word store. Depends on tws_pkg, tws_ctrl, tws_row_ram.
module trie_word_store_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tws_pkg::OP_W-1:0]     opcode,
    input  logic [tws_pkg::LETTER_W-1:0] letter,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         status
);
    import tws_pkg::*;

    ram_req_t ram_req;
    row_t     ram_rdata;
    result_t  res;
    logic     out_free;
    logic     out_valid_reg;
    logic     hit_reg;
    logic     status_reg;

    assign out_free = !out_valid_reg || out_ready;

    tws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .letter    (letter),
        .last      (last),
        .out_free  (out_free),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    tws_row_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (ROW_W),
        .AW    (NODE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            hit_reg    <= res.hit;
            status_reg <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign status    = status_reg;

endmodule

### hw/rtl/tws_checker.sv
// Port-level checks for the trie word store, bound to the top level.
// Depends on tws_pkg for field widths.
module tws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [tws_pkg::OP_W-1:0]     opcode,
    input logic [tws_pkg::LETTER_W-1:0] letter,
    input logic                         last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         hit,
    input logic                         status
);
    import tws_pkg::*;

    // offered letter holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(letter)
                                  && $stable(last))
        else $error("input changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(status))
        else $error("result changed while stalled");

    // pool full never reports a stored word
    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !hit)
        else $error("status and hit both set");

    // one letter in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second letter taken during walk step");

    // a letter that is not last cannot raise a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last && !out_valid |=> ##1 !out_valid)
        else $error("result without a last letter");

endmodule

bind trie_word_store_top tws_checker u_tws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .letter    (letter),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .status    (status)
);
